/* hdl/rpm_shift_light_bar_assert.svh */
// Assertion macros used by the checker file of the shift light block.
`ifndef RPM_SHIFT_LIGHT_BAR_ASSERT_SVH
`define RPM_SHIFT_LIGHT_BAR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RSLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RSLB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rslb_pkg.sv */
// Package: types, constants and register codes of the shift light block.
`timescale 1ns / 1ps
package rslb_pkg;

  localparam int RPM_W     = 16;
  localparam int TIME_W    = 32;
  localparam int MASK_W    = 14;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int LED_PAIRS_DEF = 7;

  // divider operand widths
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ON_RPM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_RPM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MS = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] ON_RPM_RST   = 16'd5000;
  localparam logic [CFG_W-1:0] OFF_RPM_RST  = 16'd2500;
  localparam logic [CFG_W-1:0] BAR_LOW_RST  = 16'd6500;
  localparam logic [CFG_W-1:0] BAR_HIGH_RST = 16'd9500;
  localparam logic [CFG_W-1:0] BLINK_MS_RST = 16'd150;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_LOW,
    MODE_BAR,
    MODE_HIGH
  } mode_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hdl/rslb_if.sv */
// Valid/ready channel interfaces for samples and LED results.
`timescale 1ns / 1ps
interface rslb_in_if;
  import rslb_pkg::*;
  logic              valid;
  logic              ready;
  logic [RPM_W-1:0]  rpm;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output rpm, output now_ms, input ready);
  modport sink   (input valid, input rpm, input now_ms, output ready);
endinterface

interface rslb_out_if;
  import rslb_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] led_mask;
  logic              engine_on;

  modport source (output valid, output led_mask, output engine_on, input ready);
  modport sink   (input valid, input led_mask, input engine_on, output ready);
endinterface

/* hdl/rslb_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rslb_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rslb_pkg::div_req_t req,
  output rslb_pkg::div_rsp_t rsp
);
  import rslb_pkg::*;

  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 qbit;

  // one step: shift in next dividend bit, subtract when it fits
  always_comb begin
    shifted = {rem_r, quo_r[DIV_NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    qbit    = (shifted >= {1'b0, den_r});
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo_nxt = {quo_r[DIV_NUM_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      den_r <= req.den;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

/* hdl/rpm_shift_light_bar.sv */
// Top level: engine speed shift light with hysteresis flag and LED bar graph.
// Each sample passes IDLE, DIV (bit-serial divider) and EMIT before its result is registered.
// A new sample is taken only once the last result is loaded; a stalled sink that still
//   holds the result register delays that.
// Reset (rst_n low, synchronous): engine flag off, registers to defaults, both
//   channels empty. No clearing pass.
`timescale 1ns / 1ps
module rpm_shift_light_bar #(
  parameter int LED_PAIRS = rslb_pkg::LED_PAIRS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rslb_in_if.sink                         in_ch,
  rslb_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rslb_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rslb_pkg::CFG_W-1:0]      cfg_wdata
);
  import rslb_pkg::*;

  // bar index n never reaches LED_PAIRS
  localparam int NW = $clog2(LED_PAIRS + 1);

  // configuration registers
  logic [CFG_W-1:0] on_rpm_r, off_rpm_r, bar_low_r, bar_high_r, blink_ms_r;

  // sequencer and per-sample state
  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic              flag_r, flag_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_mask_r, out_mask_nxt;
  logic              out_on_r;

  logic              in_xfer;
  logic              out_load;
  logic              in_band;
  logic [RPM_W-1:0]  rpm_ofs;
  logic [RPM_W-1:0]  span;
  logic [DIV_DEN_W-1:0] period;
  logic [NW-1:0]     bar_n;
  logic [MASK_W-1:0] bar_mask;
  logic [MASK_W-1:0] full_mask;
  logic              phase;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---------------------------------------------------------------------------
  // Configuration writes; unknown indexes fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_rpm_r   <= ON_RPM_RST;
      off_rpm_r  <= OFF_RPM_RST;
      bar_low_r  <= BAR_LOW_RST;
      bar_high_r <= BAR_HIGH_RST;
      blink_ms_r <= BLINK_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ON_RPM:   on_rpm_r   <= cfg_wdata;
        CFG_OFF_RPM:  off_rpm_r  <= cfg_wdata;
        CFG_BAR_LOW:  bar_low_r  <= cfg_wdata;
        CFG_BAR_HIGH: bar_high_r <= cfg_wdata;
        CFG_BLINK_MS: blink_ms_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: one sample at a time, taken only in IDLE.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && (state_r == ST_IDLE);

  // Hysteresis: set test first, clear test second.
  always_comb begin
    flag_nxt = flag_r;
    if (in_xfer) begin
      flag_nxt = flag_r || (in_ch.rpm > on_rpm_r);
      if (in_ch.rpm < off_rpm_r) begin
        flag_nxt = 1'b0;
      end
    end
  end

  // Band is empty by construction when high <= low.
  assign in_band = (in_ch.rpm > bar_low_r) && (in_ch.rpm < bar_high_r);

  always_comb begin
    mode_nxt = mode_r;
    if (in_xfer) begin
      priority if (!flag_nxt)                mode_nxt = MODE_OFF;
      else if (in_ch.rpm <= bar_low_r)       mode_nxt = MODE_LOW;
      else if (in_band)                      mode_nxt = MODE_BAR;
      else                                   mode_nxt = MODE_HIGH;
    end
  end

  // Divider job: bar index in the band, blink phase otherwise.
  assign rpm_ofs = in_ch.rpm - bar_low_r;
  assign span    = bar_high_r - bar_low_r;
  assign period  = (blink_ms_r == '0) ? DIV_DEN_W'(1) : blink_ms_r;

  always_comb begin
    div_req.start = in_xfer;
    if (in_band) begin
      div_req.num = DIV_NUM_W'(rpm_ofs) * DIV_NUM_W'(LED_PAIRS);
      div_req.den = span;
    end else begin
      div_req.num = in_ch.now_ms;
      div_req.den = period;
    end
  end

  rslb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE -> DIV (wait for quotient) -> EMIT (wait for result slot).
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer)      state_nxt = ST_DIV;
      ST_DIV:  if (div_rsp.done) state_nxt = ST_EMIT;
      ST_EMIT: if (out_load)     state_nxt = ST_IDLE;
      default:                   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // LED pattern from the quotient.
  assign bar_n = div_rsp.quot[NW-1:0];
  assign phase = div_rsp.quot[0];

  always_comb begin
    for (int k = 0; k < MASK_W; k++) begin
      bar_mask[k]  = (int'(bar_n) >= (k >> 1));
      full_mask[k] = ((k >> 1) < LED_PAIRS);
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_OFF:  out_mask_nxt = '0;
      MODE_LOW:  out_mask_nxt = phase ? MASK_W'(3) : '0;
      MODE_BAR:  out_mask_nxt = bar_mask;
      MODE_HIGH: out_mask_nxt = phase ? full_mask : '0;
      default:   out_mask_nxt = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_OFF;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, held while the sink stalls
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mask_r <= out_mask_nxt;
      out_on_r   <= flag_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.led_mask  = out_mask_r;
  assign out_ch.engine_on = out_on_r;

endmodule

/* hdl/rslb_checker.sv */
// Port-level checker for the shift light block, bound to the top level.
`timescale 1ns / 1ps
`include "rpm_shift_light_bar_assert.svh"
module rslb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rslb_pkg::MASK_W-1:0]   led_mask,
  input logic                          engine_on
);
  import rslb_pkg::*;

  `RSLB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, $stable(led_mask) && out_valid, "result changed while stalled")
  `RSLB_ASSERT_NXT(a_busy_after_xfer, in_valid && in_ready, !in_ready, "sample taken while busy")
  `RSLB_ASSERT_NOW(a_off_dark, out_valid && !engine_on, led_mask == '0, "LEDs lit with engine off")
  `RSLB_ASSERT_NOW(a_pair_even, out_valid, led_mask[0] == led_mask[1], "first LED pair split")

endmodule

bind rpm_shift_light_bar rslb_checker u_rslb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .led_mask  (out_ch.led_mask),
  .engine_on (out_ch.engine_on)
);
